// File: rtl/cvsm_pkg.sv
// ----------------------------------------------------------------------------
// cvsm_pkg
// shared constants and types of the cell voltage scan monitor
// ----------------------------------------------------------------------------
package cvsm_pkg;

  // pack layout
  localparam int unsigned NUM_MODULES      = 4;
  localparam int unsigned CELLS_PER_MODULE = 12;
  localparam int unsigned INDEX_STRIDE     = 12;
  localparam int unsigned SCAN_LENGTH      = NUM_MODULES * CELLS_PER_MODULE;
  localparam int unsigned MAX_INDEX        = INDEX_STRIDE * (NUM_MODULES - 1)
                                             + CELLS_PER_MODULE - 1;

  // field widths
  localparam int unsigned CODE_W  = 16;
  localparam int unsigned MV_W    = 13;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned SUM_W   = 21;
  localparam int unsigned SHIFT_W = 4;

  // scan position counters
  localparam int unsigned CELL_W = (CELLS_PER_MODULE > 1) ? $clog2(CELLS_PER_MODULE) : 1;
  localparam int unsigned MOD_W  = (NUM_MODULES > 1) ? $clog2(NUM_MODULES) : 1;

  // code to millivolts: code / 10 as (code * 52429) >> 19, exact over 16 bits
  localparam int unsigned PROD_W      = 2 * CODE_W;
  localparam logic [CODE_W-1:0] DIV10_MULT = 16'd52429;
  localparam int unsigned DIV10_SHIFT = 19;

  // moving average
  localparam int unsigned AVG_FRAC_BITS = 8;
  localparam int unsigned AVG_W         = SUM_W + AVG_FRAC_BITS;
  localparam int unsigned SHIFT_MAX     = 8;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd4;

  // output stream packing
  localparam int unsigned OUT_FIELD_W = 2 * MV_W + 2 * IDX_W + 2 * SUM_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  // figures of one finished scan
  typedef struct packed {
    logic [SUM_W-1:0] sum_mv;
    logic [IDX_W-1:0] max_idx;
    logic [MV_W-1:0]  max_mv;
    logic [IDX_W-1:0] min_idx;
    logic [MV_W-1:0]  min_mv;
  } scan_res_t;

  // one result item
  typedef struct packed {
    logic [SUM_W-1:0] avg_mv;
    scan_res_t        scan;
  } out_item_t;

endpackage

// File: rtl/cell_voltage_scan_monitor.sv
// ----------------------------------------------------------------------------
// cell_voltage_scan_monitor
// battery cell scan monitor: min/max cell, pack sum and averaged pack voltage
// ----------------------------------------------------------------------------
//  channel   | direction | payload
//  ----------+-----------+-----------------------------------------------------
//  s_axis    | in        | cell_code, one raw code per cell in scan order
//  m_axis    | out       | one item per scan: min/max cell, indices, sum, avg
//  cfg       | in        | avg_shift, log2 of the averaging length
//
//  an item is accepted every cycle while the output does not stall; a cell
//  passes an input register, a reciprocal multiply stage and the accumulate
//  stage, and a scan result then moves through the averaging stage into the
//  output register, whose valid bit drives m_axis_tvalid
//  reset clears the scan counters, accumulators and the average, no sweep
//  a stalled output fills the stages behind it; cells keep flowing while the
//  held result waits, until the last cell of a scan meets both result
//  registers full
// ----------------------------------------------------------------------------
module cell_voltage_scan_monitor (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // cell code stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [cvsm_pkg::CODE_W-1:0]      s_axis_tdata,   // [15:0] cell_code
  // scan result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [12:0] min_cell_mv, [20:13] min_cell_index, [33:21] max_cell_mv,
  // [41:34] max_cell_index, [62:42] pack_sum_mv, [83:63] pack_average_mv,
  // [87:84] zero
  output logic [cvsm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // configuration write
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [cvsm_pkg::SHIFT_W-1:0]     cfg_data_i      // [3:0] avg_shift
);
  import cvsm_pkg::*;

  // averaging shift register
  logic [SHIFT_W-1:0] avg_shift_q;

  // between conversion and accumulate
  logic               mv_valid;
  logic               mv_take;
  logic [MV_W-1:0]    mv;

  // between accumulate and averaging
  logic               res_valid;
  logic               res_ready;
  scan_res_t          res;

  out_item_t          out_item;

  // config is always accepted
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_shift_q <= SHIFT_RESET;
    end else if (cfg_valid_i) begin
      avg_shift_q <= cfg_data_i;
    end
  end

  cvsm_mv_conv u_mv_conv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_code_i  (s_axis_tdata),
    .mv_valid_o (mv_valid),
    .mv_take_i  (mv_take),
    .mv_o       (mv)
  );

  cvsm_scan_acc u_scan_acc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mv_valid_i  (mv_valid),
    .mv_take_o   (mv_take),
    .mv_i        (mv),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  cvsm_avg u_avg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .shift_i     (avg_shift_q),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (out_item)
  );

  // fields from the lowest bit up, zero fill on top
  assign m_axis_tdata = {{OUT_PAD_W{1'b0}},
                         out_item.avg_mv,
                         out_item.scan.sum_mv,
                         out_item.scan.max_idx,
                         out_item.scan.max_mv,
                         out_item.scan.min_idx,
                         out_item.scan.min_mv};

endmodule

// File: rtl/cvsm_mv_conv.sv
// ----------------------------------------------------------------------------
// cvsm_mv_conv
// input register and code to millivolt conversion stage
// ----------------------------------------------------------------------------
module cvsm_mv_conv (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [cvsm_pkg::CODE_W-1:0] in_code_i,
  output logic                       mv_valid_o,
  input  logic                       mv_take_i,
  output logic [cvsm_pkg::MV_W-1:0]  mv_o
);
  import cvsm_pkg::*;

  logic              code_v_q;
  logic [CODE_W-1:0] code_q;
  logic              mv_v_q;
  logic [MV_W-1:0]   mv_q;
  logic [MV_W-1:0]   mv_d;
  logic [PROD_W-1:0] prod;
  logic              mv_rdy;
  logic              code_rdy;

  assign mv_rdy   = !mv_v_q || mv_take_i;
  assign code_rdy = !code_v_q || mv_rdy;

  // reciprocal multiply, quotient taken from the upper bits
  assign prod = PROD_W'(code_q) * PROD_W'(DIV10_MULT);
  assign mv_d = prod[DIV10_SHIFT +: MV_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_v_q <= 1'b0;
      mv_v_q   <= 1'b0;
    end else begin
      if (code_rdy) begin
        code_v_q <= in_valid_i;
      end
      if (mv_rdy) begin
        mv_v_q <= code_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && code_rdy) begin
      code_q <= in_code_i;
    end
    if (code_v_q && mv_rdy) begin
      mv_q <= mv_d;
    end
  end

  assign in_ready_o = code_rdy;
  assign mv_valid_o = mv_v_q;
  assign mv_o       = mv_q;

endmodule

// File: rtl/cvsm_scan_acc.sv
// ----------------------------------------------------------------------------
// cvsm_scan_acc
// per-scan sum, minimum and maximum tracking with cell indexing
// ----------------------------------------------------------------------------
module cvsm_scan_acc (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      mv_valid_i,
  output logic                      mv_take_o,
  input  logic [cvsm_pkg::MV_W-1:0] mv_i,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output cvsm_pkg::scan_res_t       res_o
);
  import cvsm_pkg::*;

  logic [CELL_W-1:0] cell_q;
  logic [MOD_W-1:0]  mod_q;
  logic [IDX_W-1:0]  base_q;
  logic [SUM_W-1:0]  sum_q;
  logic [MV_W-1:0]   lo_q;
  logic [IDX_W-1:0]  lo_idx_q;
  logic [MV_W-1:0]   hi_q;
  logic [IDX_W-1:0]  hi_idx_q;
  logic              res_v_q;
  scan_res_t         res_q;

  logic              cell_last;
  logic              last;
  logic              take;
  logic [IDX_W-1:0]  idx;
  scan_res_t         upd;

  assign cell_last = (cell_q == CELL_W'(CELLS_PER_MODULE - 1));
  assign last      = cell_last && (mod_q == MOD_W'(NUM_MODULES - 1));
  assign take      = mv_valid_i && (!last || res_ready_i);
  assign idx       = base_q + IDX_W'(cell_q);

  // figures including the current cell, ties keep the earlier cell
  always_comb begin
    upd.sum_mv  = sum_q + SUM_W'(mv_i);
    upd.min_mv  = lo_q;
    upd.min_idx = lo_idx_q;
    upd.max_mv  = hi_q;
    upd.max_idx = hi_idx_q;
    if (mv_i < lo_q) begin
      upd.min_mv  = mv_i;
      upd.min_idx = idx;
    end
    if (mv_i > hi_q) begin
      upd.max_mv  = mv_i;
      upd.max_idx = idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q   <= '0;
      mod_q    <= '0;
      base_q   <= '0;
      sum_q    <= '0;
      lo_q     <= '1;
      lo_idx_q <= '0;
      hi_q     <= '0;
      hi_idx_q <= '0;
      res_v_q  <= 1'b0;
    end else begin
      if (res_ready_i) begin
        res_v_q <= take && last;
      end
      if (take) begin
        if (last) begin
          cell_q   <= '0;
          mod_q    <= '0;
          base_q   <= '0;
          sum_q    <= '0;
          lo_q     <= '1;
          lo_idx_q <= '0;
          hi_q     <= '0;
          hi_idx_q <= '0;
        end else begin
          sum_q    <= upd.sum_mv;
          lo_q     <= upd.min_mv;
          lo_idx_q <= upd.min_idx;
          hi_q     <= upd.max_mv;
          hi_idx_q <= upd.max_idx;
          if (cell_last) begin
            cell_q <= '0;
            mod_q  <= mod_q + MOD_W'(1);
            base_q <= base_q + IDX_W'(INDEX_STRIDE);
          end else begin
            cell_q <= cell_q + CELL_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && last) begin
      res_q <= upd;
    end
  end

  assign mv_take_o   = take;
  assign res_valid_o = res_v_q;
  assign res_o       = res_q;

endmodule

// File: rtl/cvsm_avg.sv
// ----------------------------------------------------------------------------
// cvsm_avg
// pack voltage moving average and output register
// ----------------------------------------------------------------------------
module cvsm_avg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [cvsm_pkg::SHIFT_W-1:0] shift_i,
  input  logic                         res_valid_i,
  output logic                         res_ready_o,
  input  cvsm_pkg::scan_res_t          res_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output cvsm_pkg::out_item_t          out_o
);
  import cvsm_pkg::*;

  logic               avg_loaded_q;
  logic [AVG_W-1:0]   avg_q;
  logic [AVG_W-1:0]   avg_d;
  logic               out_v_q;
  out_item_t          out_q;

  logic               out_rdy;
  logic               move;
  logic [SHIFT_W-1:0] shamt;
  logic [AVG_W-1:0]   target;
  logic signed [AVG_W:0] diff;
  logic signed [AVG_W:0] step;

  assign out_rdy     = !out_v_q || out_ready_i;
  assign res_ready_o = !res_valid_i || out_rdy;
  assign move        = res_valid_i && out_rdy;

  assign shamt  = (shift_i > SHIFT_W'(SHIFT_MAX)) ? SHIFT_W'(SHIFT_MAX) : shift_i;
  assign target = {res_i.sum_mv, {AVG_FRAC_BITS{1'b0}}};

  // floor shift of the signed difference covers both directions
  assign diff = $signed({1'b0, target}) - $signed({1'b0, avg_q});
  assign step = diff >>> shamt;

  assign avg_d = avg_loaded_q ? (avg_q + step[AVG_W-1:0]) : target;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_loaded_q <= 1'b0;
      avg_q        <= '0;
      out_v_q      <= 1'b0;
    end else begin
      if (out_rdy) begin
        out_v_q <= res_valid_i;
      end
      if (move) begin
        avg_loaded_q <= 1'b1;
        avg_q        <= avg_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_q.scan   <= res_i;
      out_q.avg_mv <= avg_d[AVG_W-1:AVG_FRAC_BITS];
    end
  end

  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

endmodule

// File: rtl/cvsm_checker.sv
// ----------------------------------------------------------------------------
// cvsm_checker
// port level checks of the cell voltage scan monitor, bound to the top level
// ----------------------------------------------------------------------------
module cvsm_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  input  logic [cvsm_pkg::CODE_W-1:0]      s_axis_tdata,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic [cvsm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_o,
  input  logic [cvsm_pkg::SHIFT_W-1:0]     cfg_data_i
);
  import cvsm_pkg::*;

  logic [MV_W-1:0]  min_mv;
  logic [IDX_W-1:0] min_idx;
  logic [MV_W-1:0]  max_mv;
  logic [IDX_W-1:0] max_idx;
  logic [SUM_W-1:0] sum_mv;
  logic [SUM_W-1:0] avg_mv;
  logic [OUT_PAD_W-1:0] pad;

  assign {pad, avg_mv, sum_mv, max_idx, max_mv, min_idx, min_mv} = m_axis_tdata;

  // held result stays put until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (pad == '0))
    else $error("tdata fill bits not zero");

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (min_mv <= max_mv))
    else $error("minimum cell above maximum cell");

  a_sum_covers_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (SUM_W'(max_mv) <= sum_mv))
    else $error("pack sum below highest cell");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (min_idx <= IDX_W'(MAX_INDEX)) && (max_idx <= IDX_W'(MAX_INDEX)))
    else $error("cell index outside the pack");

endmodule

bind cell_voltage_scan_monitor cvsm_checker u_cvsm_checker (.*);
